### design/sem_pkg.sv
// Package for the Sobel edge magnitude block: item types, register indexes,
// state codes and kernel constants. No dependencies.
`default_nettype none
package sem_pkg;
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        run_end;
  } out_item_t;

  typedef logic [2:0][2:0][7:0] win_t;  // [row][col] bytes of one channel

  typedef struct packed {
    logic start;
    logic done;
  } lane_ctl_t;

  localparam logic [3:0] CFG_WIDTH  = 4'd0;
  localparam logic [3:0] CFG_HEIGHT = 4'd1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  localparam logic [20:0] SAT_LIMIT = 21'd64771;  // 255*254+1
  localparam logic [7:0]  MAG_MAX   = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PICK,
    ST_CALC,
    ST_SEND
  } state_t;
endpackage
`default_nettype wire

### design/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sem_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/sem_lane.sv
// One channel lane: Sobel gradients, then a bit-serial rounded square root.
// Depends on sem_pkg.
`default_nettype none
module sem_lane
  import sem_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  win_t      win,
  output logic      done,
  output logic [7:0] mag
);
  logic              busy_r;
  logic [3:0]        step_r;
  logic signed [10:0] gx_r, gy_r;
  logic [20:0]       s_r;
  logic [7:0]        m_r;
  logic              done_r;
  logic [7:0]        mag_r;

  logic signed [10:0] gx_nxt, gy_nxt;
  logic [7:0]         bit_m, t;
  logic [15:0]        tt, mm;
  logic [20:0]        sq_sum;

  always_comb begin
    gx_nxt = 11'(signed'({3'b0, win[0][2]})) + 11'(signed'({3'b0, win[1][2]})) * 11'sd2
           + 11'(signed'({3'b0, win[2][2]}))
           - 11'(signed'({3'b0, win[0][0]})) - 11'(signed'({3'b0, win[1][0]})) * 11'sd2
           - 11'(signed'({3'b0, win[2][0]}));
    gy_nxt = 11'(signed'({3'b0, win[2][0]})) + 11'(signed'({3'b0, win[2][1]})) * 11'sd2
           + 11'(signed'({3'b0, win[2][2]}))
           - 11'(signed'({3'b0, win[0][0]})) - 11'(signed'({3'b0, win[0][1]})) * 11'sd2
           - 11'(signed'({3'b0, win[0][2]}));
    sq_sum = 21'(22'(gx_r) * 22'(gx_r) + 22'(gy_r) * 22'(gy_r));
    bit_m  = 8'h80 >> (step_r - 4'd1);
    t      = m_r | bit_m;
    tt     = 16'(t) * 16'(t);
    mm     = 16'(m_r) * 16'(m_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'd9) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
      m_r  <= '0;
    end else if (busy_r) begin
      if (step_r == 4'd0) begin
        s_r <= sq_sum;
      end else if (step_r <= 4'd8) begin
        if (21'(tt) <= s_r) begin
          m_r <= t;
        end
      end else begin
        if (s_r >= SAT_LIMIT) begin
          mag_r <= MAG_MAX;
        end else if (21'(mm) + 21'(m_r) + 21'd1 <= s_r) begin
          mag_r <= m_r + 8'd1;
        end else begin
          mag_r <= m_r;
        end
      end
    end
  end

  assign done = done_r;
  assign mag  = mag_r;
endmodule
`default_nettype wire

### design/sobel_edge_magnitude_core.sv
// Top level of the streaming RGB Sobel edge magnitude block: raster counters,
// line store RAM, window, three channel lanes and the result merge/sequencer.
// Depends on sem_pkg, sem_ram and sem_lane.
//
// Pixels enter in raster order; each produces zero to four results, each
// tagged with its row and column, run_end set on the last one. One item is
// handled at a time: the line store read and write-back, then per result a
// pick state, the lanes (gradients, square, eight root steps, rounding,
// output load) and the output handshake, plus a final pick state. The line
// store is a single RAM of MAX_WIDTH words, each holding both previous rows
// for one column.
`default_nettype none
module sobel_edge_magnitude_core
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_index,
  input  wire logic [11:0] cfg_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = 15;

  state_t state_r, state_nxt;
  logic [10:0] fw_r;
  logic [11:0] fh_r;
  logic [11:0] row_r;
  logic [CW-1:0] col_r;
  logic [23:0] px_r, cur0_r, cur1_r;
  logic [2:0][23:0] wc0_r, wc1_r;
  logic last_col_r, last_row_r;
  logic [3:0] pend_r;
  logic [1:0] k_r;
  logic start_r;
  out_item_t out_r;

  logic [WW-1:0] w_eff;
  logic [11:0]   h_eff;
  logic          last_col, last_row;
  logic [47:0]   rd_data;
  logic          ram_we;
  logic [1:0]    k_sel;
  logic [2:0][23:0] colz, cur, wz0, wz1, lc, mc, rc;
  win_t win_r, win_g, win_b;
  lane_ctl_t ctl_r, ctl_g, ctl_b;
  logic [7:0] mag_r, mag_g, mag_b;
  logic [3:0] pend_left;

  always_comb begin
    if (fw_r == 11'd0) begin
      w_eff = WW'(1);
    end else if (WW'(fw_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    h_eff    = (fh_r == 12'd0) ? 12'd1 : fh_r;
    last_col = WW'(col_r) >= w_eff - WW'(1);
    last_row = row_r >= h_eff - 12'd1;
  end

  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign ram_we    = (state_r == ST_READ);

  sem_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(col_r),
    .wdata({rd_data[23:0], px_r}),
    .raddr(col_r),
    .rdata(rd_data)
  );

  always_comb begin
    colz = '0;
    cur  = {px_r, cur1_r, cur0_r};  // index 0 top, 2 bottom
    wz0  = (col_r == '0) ? colz : wc0_r;
    wz1  = (col_r == '0) ? colz : wc1_r;
    k_sel = pend_r[0] ? 2'd0 : pend_r[1] ? 2'd1 : pend_r[2] ? 2'd2 : 2'd3;
    if (k_sel[0]) begin
      lc = wz1; mc = cur; rc = colz;
    end else begin
      lc = wz0; mc = wz1; rc = cur;
    end
    if (k_sel[1]) begin
      lc = {24'd0, lc[2], lc[1]};
      mc = {24'd0, mc[2], mc[1]};
      rc = {24'd0, rc[2], rc[1]};
    end
    for (int r = 0; r < 3; r++) begin
      win_r[r] = {rc[r][23:16], mc[r][23:16], lc[r][23:16]};
      win_g[r] = {rc[r][15:8],  mc[r][15:8],  lc[r][15:8]};
      win_b[r] = {rc[r][7:0],   mc[r][7:0],   lc[r][7:0]};
    end
    pend_left = pend_r & ~(4'b0001 << k_r);
  end

  assign ctl_r.start = start_r;
  assign ctl_g.start = start_r;
  assign ctl_b.start = start_r;

  sem_lane u_lane_r (.clk(clk), .rst_n(rst_n), .start(ctl_r.start), .win(win_r),
                     .done(ctl_r.done), .mag(mag_r));
  sem_lane u_lane_g (.clk(clk), .rst_n(rst_n), .start(ctl_g.start), .win(win_g),
                     .done(ctl_g.done), .mag(mag_g));
  sem_lane u_lane_b (.clk(clk), .rst_n(rst_n), .start(ctl_b.start), .win(win_b),
                     .done(ctl_b.done), .mag(mag_b));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && !(cfg_valid)) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_PICK;
      ST_PICK: state_nxt = (pend_r == '0) ? ST_IDLE : ST_CALC;
      ST_CALC: if (ctl_r.done) state_nxt = ST_SEND;
      ST_SEND: if (out_ready) state_nxt = ST_PICK;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fw_r    <= WIDTH_RESET;
      fh_r    <= HEIGHT_RESET;
      row_r   <= '0;
      col_r   <= '0;
      wc0_r   <= '0;
      wc1_r   <= '0;
      pend_r  <= '0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_WIDTH) begin
              fw_r  <= cfg_data[10:0];
              row_r <= '0;
              col_r <= '0;
            end else if (cfg_index == CFG_HEIGHT) begin
              fh_r  <= cfg_data;
              row_r <= '0;
              col_r <= '0;
            end
          end
        end
        ST_READ: begin
          pend_r <= {last_row_r && last_col_r, last_row_r && (col_r != '0),
                     (row_r != '0) && last_col_r, (row_r != '0) && (col_r != '0)};
        end
        ST_PICK: begin
          if (pend_r == '0) begin
            wc0_r <= wz1;
            wc1_r <= cur;
            if (last_col_r) begin
              col_r <= '0;
              row_r <= last_row_r ? 12'd0 : row_r + 12'd1;
            end else begin
              col_r <= col_r + CW'(1);
            end
          end else begin
            start_r <= 1'b1;
          end
        end
        ST_CALC: begin
          if (ctl_r.done) begin
            pend_r <= pend_left;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      px_r       <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      last_col_r <= last_col;
      last_row_r <= last_row;
    end
    if (state_r == ST_READ) begin
      cur0_r <= (row_r >= 12'd2) ? rd_data[47:24] : 24'd0;
      cur1_r <= (row_r >= 12'd1) ? rd_data[23:0]  : 24'd0;
    end
    if (state_r == ST_PICK) begin
      k_r <= k_sel;
    end
    if (state_r == ST_CALC && ctl_r.done) begin
      out_r.out_row   <= k_r[1] ? row_r : row_r - 12'd1;
      out_r.out_col   <= k_r[0] ? 10'(col_r) : 10'(col_r - CW'(1));
      out_r.red_out   <= mag_r;
      out_r.green_out <= mag_g;
      out_r.blue_out  <= mag_b;
      out_r.run_end   <= (pend_left == '0);
    end
  end

  assign out_valid = (state_r == ST_SEND);
  assign out_data  = out_r;

  a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.done |-> (ctl_g.done && ctl_b.done && state_r == ST_CALC))
    else $error("lane completion out of step");
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");
  a_start_pend: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (pend_r != '0))
    else $error("lane started with no result pending");
  a_send_next: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (state_r == ST_PICK))
    else $error("result handshake did not return to pick");
endmodule
`default_nettype wire
